// ===== rtl/hrhp_pkg.sv =====
package hrhp_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;
    localparam int CL_NAME_LEN = 14;
    localparam int POS_BITS = 4;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CTL_LAST   = 8'h1F;

    localparam logic [1:0] STATUS_MORE  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [2:0] CLASS_NONE   = 3'd0;
    localparam logic [2:0] CLASS_METHOD = 3'd1;
    localparam logic [2:0] CLASS_URI    = 3'd2;
    localparam logic [2:0] CLASS_NAME   = 3'd3;
    localparam logic [2:0] CLASS_VALUE  = 3'd4;

    typedef enum logic [21:0] {
        ST_METHOD_START = 22'h000001,
        ST_METHOD       = 22'h000002,
        ST_URI          = 22'h000004,
        ST_H            = 22'h000008,
        ST_T1           = 22'h000010,
        ST_T2           = 22'h000020,
        ST_P            = 22'h000040,
        ST_SLASH        = 22'h000080,
        ST_MAJOR_START  = 22'h000100,
        ST_MAJOR        = 22'h000200,
        ST_MINOR_START  = 22'h000400,
        ST_MINOR        = 22'h000800,
        ST_NL1          = 22'h001000,
        ST_LINE_START   = 22'h002000,
        ST_LWS          = 22'h004000,
        ST_NAME         = 22'h008000,
        ST_SPACE        = 22'h010000,
        ST_VALUE        = 22'h020000,
        ST_NL2          = 22'h040000,
        ST_NL3          = 22'h080000,
        ST_DONE         = 22'h100000,
        ST_ERROR        = 22'h200000
    } parse_state_t;

    typedef enum logic [3:0] {
        PH_NONE    = 4'b0001,
        PH_LEAD    = 4'b0010,
        PH_DIGITS  = 4'b0100,
        PH_STOPPED = 4'b1000
    } length_phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  byte_class;
        logic        header_start;
        logic [15:0] version_major;
        logic [15:0] version_minor;
        logic [31:0] body_length;
        logic        length_found;
    } result_t;

    function automatic logic is_ctl(input logic [7:0] b);
        return (b <= CTL_LAST) || (b == CHAR_DEL);
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        logic ok;
        ok = !b[7] && !is_ctl(b);
        case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40,
            8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D,
            8'h7B, 8'h7D, 8'h20, 8'h09: ok = 1'b0;
            default: ;
        endcase
        return ok;
    endfunction

    // Characters of "Content-Length", indexed by position in the name.
    function automatic logic [7:0] cl_name_char(input logic [POS_BITS-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/http_request_header_parser.sv =====
// HTTP/1.1 request header parser. One byte word enters per cycle (op 0 consumes data_byte,
// op 1 restarts at the method) and each accepted word yields exactly one result word, computed
// from the next state of the parse state machine and registered at the edge that updates it:
// the sustained rate is one word per clock while out_stall is low. A two-entry output stage
// lets a new word be accepted while a result still waits; in_stall rises only when both
// entries are full. Each result carries the status (more, done, malformed), the class of
// the byte, a header-start flag, the saturating HTTP version numbers and the value of the
// first Content-Length header, saturating at 2^LENGTH_BITS-1 and shown as its low 32 bits.
module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [2:0]  byte_class,
    output logic        header_start,
    output logic [15:0] version_major,
    output logic [15:0] version_minor,
    output logic [31:0] body_length,
    output logic        length_found
);

    parse_state_t            state_reg, state_next;
    length_phase_t           phase_reg, phase_next, feed_phase;
    logic                    seen_reg, seen_next;
    logic [15:0]             major_reg, major_next;
    logic [15:0]             minor_reg, minor_next;
    logic [POS_BITS-1:0]     pos_reg, pos_next;
    logic                    match_reg, match_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next, feed_len;

    result_t out_reg, out_next, skid_reg, result;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic                    accept, take;
    logic [3:0]              digit;
    logic [19:0]             major_acc, minor_acc;
    logic [15:0]             major_sat, minor_sat;
    logic [LENGTH_BITS+3:0]  len_acc;
    logic [LENGTH_BITS-1:0]  len_sat;
    logic [LENGTH_BITS+31:0] len_wide;
    logic                    is_sp_tab, name_hit;
    logic                    bad;
    logic [2:0]              cls;
    logic                    hstart;

    assign accept = in_valid && !in_stall;
    assign take   = out_valid_reg && !out_stall;

    assign digit     = 4'(data_byte - CHAR_ZERO);
    assign is_sp_tab = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);

    // Decimal accumulators: v*10 + d as two shifts and two adds, saturating on carry-out.
    assign major_acc = ({4'd0, major_reg} << 3) + ({4'd0, major_reg} << 1) + 20'(digit);
    assign minor_acc = ({4'd0, minor_reg} << 3) + ({4'd0, minor_reg} << 1) + 20'(digit);
    assign major_sat = (major_acc[19:16] != 4'd0) ? 16'hFFFF : major_acc[15:0];
    assign minor_sat = (minor_acc[19:16] != 4'd0) ? 16'hFFFF : minor_acc[15:0];
    assign len_acc   = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1)
                     + (LENGTH_BITS+4)'(digit);
    assign len_sat   = (len_acc[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
                     : len_acc[LENGTH_BITS-1:0];

    assign name_hit = match_reg && (pos_reg < POS_BITS'(CL_NAME_LEN))
                   && (data_byte == cl_name_char(pos_reg));

    // Content-Length value scan for one value byte.
    always_comb
    begin
        feed_phase = phase_reg;
        feed_len   = len_reg;
        case (phase_reg)
            PH_LEAD:
            begin
                if (!is_sp_tab)
                begin
                    feed_phase = is_decimal(data_byte) ? PH_DIGITS : PH_STOPPED;
                end
            end
            PH_DIGITS:
            begin
                if (!is_decimal(data_byte))
                begin
                    feed_phase = PH_STOPPED;
                end
            end
            default: ;
        endcase
        if (feed_phase == PH_DIGITS)
        begin
            feed_len = len_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        major_next = major_reg;
        minor_next = minor_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        len_next   = len_reg;
        bad        = 1'b0;
        cls        = CLASS_NONE;
        hstart     = 1'b0;

        if (op)
        begin
            state_next = ST_METHOD_START;
            phase_next = PH_NONE;
            seen_next  = 1'b0;
            major_next = '0;
            minor_next = '0;
            pos_next   = '0;
            match_next = 1'b0;
            len_next   = '0;
        end
        else
        begin
            case (state_reg)
                ST_METHOD_START:
                begin
                    if (is_token(data_byte))
                    begin
                        state_next = ST_METHOD;
                        cls = CLASS_METHOD;
                    end
                    else bad = 1'b1;
                end
                ST_METHOD:
                begin
                    if (data_byte == CHAR_SPACE) state_next = ST_URI;
                    else if (is_token(data_byte)) cls = CLASS_METHOD;
                    else bad = 1'b1;
                end
                ST_URI:
                begin
                    if (data_byte == CHAR_SPACE) state_next = ST_H;
                    else if (is_ctl(data_byte)) bad = 1'b1;
                    else cls = CLASS_URI;
                end
                ST_H:
                begin
                    if (data_byte == CHAR_H) state_next = ST_T1;
                    else bad = 1'b1;
                end
                ST_T1:
                begin
                    if (data_byte == CHAR_T) state_next = ST_T2;
                    else bad = 1'b1;
                end
                ST_T2:
                begin
                    if (data_byte == CHAR_T) state_next = ST_P;
                    else bad = 1'b1;
                end
                ST_P:
                begin
                    if (data_byte == CHAR_P) state_next = ST_SLASH;
                    else bad = 1'b1;
                end
                ST_SLASH:
                begin
                    if (data_byte == CHAR_SLASH)
                    begin
                        major_next = '0;
                        minor_next = '0;
                        state_next = ST_MAJOR_START;
                    end
                    else bad = 1'b1;
                end
                ST_MAJOR_START, ST_MAJOR:
                begin
                    if (state_reg == ST_MAJOR && data_byte == CHAR_DOT)
                    begin
                        state_next = ST_MINOR_START;
                    end
                    else if (is_decimal(data_byte))
                    begin
                        major_next = major_sat;
                        state_next = ST_MAJOR;
                    end
                    else bad = 1'b1;
                end
                ST_MINOR_START, ST_MINOR:
                begin
                    if (state_reg == ST_MINOR && data_byte == CHAR_CR)
                    begin
                        state_next = ST_NL1;
                    end
                    else if (is_decimal(data_byte))
                    begin
                        minor_next = minor_sat;
                        state_next = ST_MINOR;
                    end
                    else bad = 1'b1;
                end
                ST_NL1:
                begin
                    if (data_byte == CHAR_LF) state_next = ST_LINE_START;
                    else bad = 1'b1;
                end
                ST_LINE_START:
                begin
                    if (data_byte == CHAR_CR) state_next = ST_NL3;
                    else if (seen_reg && is_sp_tab) state_next = ST_LWS;
                    else if (is_token(data_byte))
                    begin
                        // A new header line ends any Content-Length value scan in progress.
                        seen_next = 1'b1;
                        if (phase_reg == PH_LEAD || phase_reg == PH_DIGITS)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        if (data_byte == cl_name_char('0))
                        begin
                            match_next = 1'b1;
                            pos_next   = POS_BITS'(1);
                        end
                        else
                        begin
                            match_next = 1'b0;
                            pos_next   = '0;
                        end
                        state_next = ST_NAME;
                        cls    = CLASS_NAME;
                        hstart = 1'b1;
                    end
                    else bad = 1'b1;
                end
                ST_LWS:
                begin
                    if (data_byte == CHAR_CR) state_next = ST_NL2;
                    else if (is_sp_tab) ;
                    else if (is_ctl(data_byte)) bad = 1'b1;
                    else
                    begin
                        phase_next = feed_phase;
                        len_next   = feed_len;
                        state_next = ST_VALUE;
                        cls = CLASS_VALUE;
                    end
                end
                ST_NAME:
                begin
                    if (data_byte == CHAR_COLON)
                    begin
                        if (match_reg && pos_reg == POS_BITS'(CL_NAME_LEN)
                            && phase_reg == PH_NONE)
                        begin
                            phase_next = PH_LEAD;
                        end
                        match_next = 1'b0;
                        state_next = ST_SPACE;
                    end
                    else if (is_token(data_byte))
                    begin
                        if (name_hit) pos_next = pos_reg + POS_BITS'(1);
                        else match_next = 1'b0;
                        cls = CLASS_NAME;
                    end
                    else bad = 1'b1;
                end
                ST_SPACE:
                begin
                    if (data_byte == CHAR_SPACE) state_next = ST_VALUE;
                    else bad = 1'b1;
                end
                ST_VALUE:
                begin
                    if (data_byte == CHAR_CR) state_next = ST_NL2;
                    else if (is_ctl(data_byte)) bad = 1'b1;
                    else
                    begin
                        phase_next = feed_phase;
                        len_next   = feed_len;
                        cls = CLASS_VALUE;
                    end
                end
                ST_NL2:
                begin
                    if (data_byte == CHAR_LF) state_next = ST_LINE_START;
                    else bad = 1'b1;
                end
                ST_NL3:
                begin
                    if (data_byte == CHAR_LF) state_next = ST_DONE;
                    else bad = 1'b1;
                end
                ST_DONE: ;
                default: state_next = ST_ERROR;
            endcase
            if (bad)
            begin
                state_next = ST_ERROR;
                cls    = CLASS_NONE;
                hstart = 1'b0;
            end
        end
    end

    assign len_wide = {32'd0, len_next};

    always_comb
    begin
        if (state_next == ST_ERROR) result.status = STATUS_ERROR;
        else if (state_next == ST_DONE) result.status = STATUS_DONE;
        else result.status = STATUS_MORE;
        result.byte_class     = cls;
        result.header_start   = hstart;
        result.version_major  = major_next;
        result.version_minor  = minor_next;
        result.body_length    = len_wide[31:0];
        result.length_found   = (phase_next != PH_NONE);
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_METHOD_START;
            phase_reg      <= PH_NONE;
            seen_reg       <= 1'b0;
            major_reg      <= '0;
            minor_reg      <= '0;
            pos_reg        <= '0;
            match_reg      <= 1'b0;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                major_reg <= major_next;
                minor_reg <= minor_next;
                pos_reg   <= pos_next;
                match_reg <= match_next;
                len_reg   <= len_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (accept && out_valid_reg && !take)
        begin
            skid_reg <= result;
        end
    end

    assign in_stall       = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign byte_class     = out_reg.byte_class;
    assign header_start   = out_reg.header_start;
    assign version_major  = out_reg.version_major;
    assign version_minor  = out_reg.version_minor;
    assign body_length    = out_reg.body_length;
    assign length_found   = out_reg.length_found;

endmodule

// ===== test/http_request_header_parser_tb.sv =====
module http_request_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrhp_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int ITEM_TARGET    = 2000;
    localparam int CALM_AFTER     = 1700;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PRINT_LIMIT    = 100;

    class request_tracker;
        parse_state_t  pstate;
        bit            seen_header;
        bit [15:0]     major_num;
        bit [15:0]     minor_num;
        bit [3:0]      name_pos;
        bit            name_match;
        length_phase_t len_phase;
        bit [31:0]     len_value;
        result_t       expected_results[$];
        int            mismatches;
        string         length_name = "Content-Length";

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            pstate      = ST_METHOD_START;
            seen_header = 1'b0;
            major_num   = '0;
            minor_num   = '0;
            name_pos    = '0;
            name_match  = 1'b0;
            len_phase   = PH_NONE;
            len_value   = '0;
        endfunction

        function bit is_control(bit [7:0] c);
            return (c <= CTL_LAST) || (c == CHAR_DEL);
        endfunction

        function bit is_num(bit [7:0] c);
            return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        endfunction

        function bit is_blank(bit [7:0] c);
            return (c == CHAR_SPACE) || (c == CHAR_TAB);
        endfunction

        function bit is_name_char(bit [7:0] c);
            string seps = "()<>@,;:\\\"/[]?={} ";
            if (c[7] || is_control(c))
                return 1'b0;
            foreach (seps[i])
                if (seps[i] == c)
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit [15:0] add_digit(bit [15:0] v, bit [7:0] c);
            int unsigned n;
            n = v * 10 + (c - CHAR_ZERO);
            return (n > 65535) ? 16'hFFFF : n[15:0];
        endfunction

        function void match_name(bit [7:0] c);
            if (name_match && name_pos < CL_NAME_LEN && c == length_name[name_pos])
                name_pos++;
            else
                name_match = 1'b0;
        endfunction

        // Leading blanks are skipped, digits accumulate, and anything else freezes the value.
        function void scan_length(bit [7:0] c);
            longint unsigned n;
            if (len_phase == PH_LEAD)
            begin
                if (is_blank(c))
                    return;
                if (is_num(c))
                    len_phase = PH_DIGITS;
                else
                    len_phase = PH_STOPPED;
            end
            else if (len_phase == PH_DIGITS && !is_num(c))
            begin
                len_phase = PH_STOPPED;
            end
            if (len_phase == PH_DIGITS)
            begin
                n = len_value * 64'd10 + (c - CHAR_ZERO);
                len_value = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
            end
        endfunction

        function void note_word(bit restart, bit [7:0] c);
            parse_state_t nxt;
            bit           bad;
            logic [2:0]   cls;
            bit           hs;
            result_t      r;
            bad = 1'b0;
            cls = CLASS_NONE;
            hs  = 1'b0;
            if (restart)
            begin
                clear();
                nxt = ST_METHOD_START;
            end
            else
            begin
                nxt = pstate;
                case (pstate)
                    ST_METHOD_START:
                        if (is_name_char(c))
                        begin
                            nxt = ST_METHOD;
                            cls = CLASS_METHOD;
                        end
                        else bad = 1'b1;
                    ST_METHOD:
                        if (c == CHAR_SPACE) nxt = ST_URI;
                        else if (is_name_char(c)) cls = CLASS_METHOD;
                        else bad = 1'b1;
                    ST_URI:
                        if (c == CHAR_SPACE) nxt = ST_H;
                        else if (is_control(c)) bad = 1'b1;
                        else cls = CLASS_URI;
                    ST_H:
                        if (c == CHAR_H) nxt = ST_T1; else bad = 1'b1;
                    ST_T1:
                        if (c == CHAR_T) nxt = ST_T2; else bad = 1'b1;
                    ST_T2:
                        if (c == CHAR_T) nxt = ST_P; else bad = 1'b1;
                    ST_P:
                        if (c == CHAR_P) nxt = ST_SLASH; else bad = 1'b1;
                    ST_SLASH:
                        if (c == CHAR_SLASH)
                        begin
                            major_num = '0;
                            minor_num = '0;
                            nxt = ST_MAJOR_START;
                        end
                        else bad = 1'b1;
                    ST_MAJOR_START, ST_MAJOR:
                        if (pstate == ST_MAJOR && c == CHAR_DOT) nxt = ST_MINOR_START;
                        else if (is_num(c))
                        begin
                            major_num = add_digit(major_num, c);
                            nxt = ST_MAJOR;
                        end
                        else bad = 1'b1;
                    ST_MINOR_START, ST_MINOR:
                        if (pstate == ST_MINOR && c == CHAR_CR) nxt = ST_NL1;
                        else if (is_num(c))
                        begin
                            minor_num = add_digit(minor_num, c);
                            nxt = ST_MINOR;
                        end
                        else bad = 1'b1;
                    ST_NL1:
                        if (c == CHAR_LF) nxt = ST_LINE_START; else bad = 1'b1;
                    ST_LINE_START:
                        if (c == CHAR_CR) nxt = ST_NL3;
                        else if (seen_header && is_blank(c)) nxt = ST_LWS;
                        else if (is_name_char(c))
                        begin
                            // A new header closes any Content-Length value still being read.
                            seen_header = 1'b1;
                            if (len_phase == PH_LEAD || len_phase == PH_DIGITS)
                                len_phase = PH_STOPPED;
                            name_match = 1'b1;
                            name_pos   = '0;
                            match_name(c);
                            nxt = ST_NAME;
                            cls = CLASS_NAME;
                            hs  = 1'b1;
                        end
                        else bad = 1'b1;
                    ST_LWS:
                        if (c == CHAR_CR) nxt = ST_NL2;
                        else if (is_blank(c)) ;
                        else if (is_control(c)) bad = 1'b1;
                        else
                        begin
                            scan_length(c);
                            nxt = ST_VALUE;
                            cls = CLASS_VALUE;
                        end
                    ST_NAME:
                        if (c == CHAR_COLON)
                        begin
                            if (name_match && name_pos == CL_NAME_LEN && len_phase == PH_NONE)
                                len_phase = PH_LEAD;
                            name_match = 1'b0;
                            nxt = ST_SPACE;
                        end
                        else if (is_name_char(c))
                        begin
                            match_name(c);
                            cls = CLASS_NAME;
                        end
                        else bad = 1'b1;
                    ST_SPACE:
                        if (c == CHAR_SPACE) nxt = ST_VALUE; else bad = 1'b1;
                    ST_VALUE:
                        if (c == CHAR_CR) nxt = ST_NL2;
                        else if (is_control(c)) bad = 1'b1;
                        else
                        begin
                            scan_length(c);
                            cls = CLASS_VALUE;
                        end
                    ST_NL2:
                        if (c == CHAR_LF) nxt = ST_LINE_START; else bad = 1'b1;
                    ST_NL3:
                        if (c == CHAR_LF) nxt = ST_DONE; else bad = 1'b1;
                    ST_DONE: ;
                    default: nxt = ST_ERROR;
                endcase
                if (bad)
                begin
                    nxt = ST_ERROR;
                    cls = CLASS_NONE;
                    hs  = 1'b0;
                end
                pstate = nxt;
            end
            if (nxt == ST_ERROR)
                r.status = STATUS_ERROR;
            else if (nxt == ST_DONE)
                r.status = STATUS_DONE;
            else
                r.status = STATUS_MORE;
            r.byte_class     = cls;
            r.header_start   = hs;
            r.version_major  = major_num;
            r.version_minor  = minor_num;
            r.body_length    = len_value;
            r.length_found   = (len_phase != PH_NONE);
            expected_results.insert(expected_results.size(), r);
        endfunction

        task report_mismatch(string field, longint unsigned got, longint unsigned want);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
            mismatches++;
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.byte_class !== want.byte_class)
                report_mismatch("byte_class", got.byte_class, want.byte_class);
            if (got.header_start !== want.header_start)
                report_mismatch("header_start", got.header_start, want.header_start);
            if (got.version_major !== want.version_major)
                report_mismatch("version_major", got.version_major, want.version_major);
            if (got.version_minor !== want.version_minor)
                report_mismatch("version_minor", got.version_minor, want.version_minor);
            if (got.body_length !== want.body_length)
                report_mismatch("body_length", got.body_length, want.body_length);
            if (got.length_found !== want.length_found)
                report_mismatch("length_found", got.length_found, want.length_found);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [2:0]  byte_class;
    logic        header_start;
    logic [15:0] version_major;
    logic [15:0] version_minor;
    logic [31:0] body_length;
    logic        length_found;
    result_t     seen_word;

    request_tracker sb;
    logic [8:0]     words[$];
    int             live_words = 0;
    bit             calm = 1'b0;
    int             quiet_cycles = 0;

    http_request_header_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .byte_class     (byte_class),
        .header_start   (header_start),
        .version_major  (version_major),
        .version_minor  (version_minor),
        .body_length    (body_length),
        .length_found   (length_found)
    );

    assign seen_word = {status, byte_class, header_start, version_major, version_minor,
                        body_length, length_found};

    always #HALF_PERIOD clk = ~clk;

    function void put(logic [7:0] c);
        words.insert(words.size(), {1'b0, c});
    endfunction

    function void put_text(string s);
        foreach (s[i])
            put(s[i]);
    endfunction

    function void put_restart();
        words.insert(words.size(), {1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function void put_digits(int n);
        repeat (n)
            put(8'(CHAR_ZERO + $urandom_range(0, 9)));
    endfunction

    function void put_blank();
        put($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    endfunction

    function void put_eol();
        put(CHAR_CR);
        put(CHAR_LF);
    endfunction

    function logic [7:0] token_char();
        string pool;
        pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // Printable or non-ASCII, never a control character and never a space.
    function logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 255));
        while (c == CHAR_DEL);
        return c;
    endfunction

    function logic [7:0] value_char();
        return ($urandom_range(0, 5) == 0) ? CHAR_SPACE : text_char();
    endfunction

    function int version_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 2);
    endfunction

    function string near_miss_name();
        case ($urandom_range(0, 3))
            0:       return "content-length";
            1:       return "Content-Len";
            2:       return "Content-Lengths";
            default: return "Content_Length";
        endcase
    endfunction

    function void build_request();
        int base;
        int kind;
        int idx;
        base = words.size();
        put_restart();
        repeat ($urandom_range(1, 6)) put(token_char());
        put(CHAR_SPACE);
        repeat ($urandom_range(1, 8)) put(text_char());
        put(CHAR_SPACE);
        put_text("HTTP/");
        put_digits(version_len());
        put(CHAR_DOT);
        put_digits(version_len());
        put_eol();
        repeat ($urandom_range(0, 4))
        begin
            kind = $urandom_range(0, 5);
            if (kind <= 1)
                put_text("Content-Length");
            else if (kind == 2)
                put_text(near_miss_name());
            else
                repeat ($urandom_range(1, 8)) put(token_char());
            put(CHAR_COLON);
            put(CHAR_SPACE);
            if (kind <= 2)
            begin
                repeat ($urandom_range(0, 3)) put_blank();
                put_digits(($urandom_range(0, 5) == 0) ? $urandom_range(11, 14)
                                                       : $urandom_range(0, 6));
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3)) put(value_char());
            end
            else
            begin
                repeat ($urandom_range(0, 8)) put(value_char());
            end
            // Continuation line, which may carry more digits of the value.
            if ($urandom_range(0, 3) == 0)
            begin
                put_eol();
                repeat ($urandom_range(1, 2)) put_blank();
                if ($urandom_range(0, 1))
                    put_digits($urandom_range(1, 3));
                else
                    repeat ($urandom_range(0, 5)) put(value_char());
            end
            put_eol();
        end
        put_eol();
        repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0 && words.size() > base + 1)
        begin
            idx = $urandom_range(base + 1, words.size() - 1);
            words[idx] = {($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))};
        end
    endfunction

    function void build_noise();
        put_restart();
        repeat ($urandom_range(5, 20)) put(8'($urandom_range(0, 255)));
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task send_word(logic restart, logic [7:0] c);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= restart;
        data_byte <= c;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        live_words++;
        calm = (live_words >= CALM_AFTER);
        sb.note_word(restart, c);
        @(negedge clk);
    endtask

    task drain_words();
        logic [8:0] w;
        while (words.size() != 0)
        begin
            w = words.pop_front();
            send_word(w[8], w[7:0]);
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_word(seen_word);
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = 1'b0;
        data_byte = 8'h00;
        sb        = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Non-ASCII first byte, a byte after the error, restarts, DEL as a method byte,
        // a non-ASCII URI byte, and a continuation line before any header.
        put(8'hFF);
        put(8'h41);
        words.insert(words.size(), {1'b1, 8'hFF});
        put(CHAR_DEL);
        words.insert(words.size(), {1'b1, 8'h00});
        put_text("M");
        put(CHAR_SPACE);
        put(8'h80);
        put(CHAR_SPACE);
        put_text("HTTP/9.9");
        put_eol();
        put(CHAR_SPACE);
        drain_words();

        while (live_words < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                build_noise();
            else
                build_request();
            drain_words();
        end
        in_valid <= 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
